>>> hw/rtl/tblpm_pkg.sv
// Shared types, constants and helper functions for the tree-bitmap LPM lookup unit.
// Used by the controller, the datapath and the top level; depends on nothing else.
`default_nettype none

package tblpm_pkg;

   // Table sizes.
   localparam int CAM_ENTRIES      = 64;
   localparam int NODE_STORE_DEPTH = 1024;
   localparam int SUBTRIE_DEPTH    = 1024;
   localparam int TRIE_KEY_BYTES   = 16;

   localparam int CAM_AW     = $clog2(CAM_ENTRIES);
   localparam int NODE_AW    = $clog2(NODE_STORE_DEPTH);
   localparam int SUB_AW     = $clog2(SUBTRIE_DEPTH);
   localparam int WORD_AW    = NODE_AW + 2;
   localparam int LVL_W      = $clog2(TRIE_KEY_BYTES + 1);
   localparam int MAX_TRIE   = TRIE_KEY_BYTES * 8;
   localparam int PTR_W      = 10;
   localparam int REC_W      = 2 * PTR_W;
   localparam int ACT_W      = 16;
   localparam int APTR_W     = ACT_W + 1;
   localparam int CNT_W      = 9;

   // Request kinds.
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_WRITE  = 1'b1;

   // Write targets.
   localparam logic [2:0] TGT_CAM_KEY    = 3'd0;
   localparam logic [2:0] TGT_CAM_INVERT = 3'd1;
   localparam logic [2:0] TGT_CAM_ROOT   = 3'd2;
   localparam logic [2:0] TGT_SUB_REC    = 3'd3;
   localparam logic [2:0] TGT_PREFIX     = 3'd4;
   localparam logic [2:0] TGT_CHILD      = 3'd5;
   localparam logic [2:0] TGT_ACTION     = 3'd6;

   typedef struct packed {
      logic        req_type;
      logic [2:0]  write_target;
      logic [9:0]  write_index;
      logic [1:0]  write_word;
      logic [63:0] write_data;
      logic [31:0] cam_key;
      logic [63:0] trie_key_high;
      logic [63:0] trie_key_low;
      logic [7:0]  key_length;
   } req_word_type;

   typedef struct packed {
      logic        hit;
      logic [20:0] forward_index;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load_req;
      logic             wr_en;
      logic             cam_cmp;
      logic             cam_sel;
      logic             root_load;
      logic             rd_issue;
      logic [1:0]       rd_word;
      logic             cap_en;
      logic [1:0]       cap_word;
      logic             decide;
      logic             cnt_en;
      logic [1:0]       cnt_word;
      logic             next_lvl;
      logic             sub_load;
      logic             rsp_load;
      logic [LVL_W-1:0] lvl;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cam_hit;
      logic walk_end;
   } sts_type;

   // Mask of the bits of word w that sit at bitmap positions below pos.
   function automatic logic [63:0] before_mask(input logic [1:0] w, input logic [7:0] pos);
      logic [63:0] m;
      if (w < pos[7:6]) begin
         m = {64{1'b1}};
      end else if (w == pos[7:6]) begin
         m = ~({64{1'b1}} >> pos[5:0]);
      end else begin
         m = '0;
      end
      return m;
   endfunction

   function automatic logic [6:0] popcount64(input logic [63:0] v);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         n = n + 7'(v[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tblpm_ctrl.sv
// Controller state machine for the tree-bitmap LPM lookup unit.
// Depends on tblpm_pkg; drives the datapath through cmd_type and reads sts_type.
`default_nettype none

module tblpm_ctrl
   import tblpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire logic    req_is_write,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CAM_CMP = 4'd1;
   localparam logic [3:0] ST_CAM_SEL = 4'd2;
   localparam logic [3:0] ST_ROOT    = 4'd3;
   localparam logic [3:0] ST_READ    = 4'd4;
   localparam logic [3:0] ST_DECIDE  = 4'd5;
   localparam logic [3:0] ST_COUNT   = 4'd6;
   localparam logic [3:0] ST_NEXT    = 4'd7;
   localparam logic [3:0] ST_SUB     = 4'd8;
   localparam logic [3:0] ST_FINISH  = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic [2:0]       wcnt_ff, wcnt_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      wcnt_in  = wcnt_ff;
      lvl_in   = lvl_ff;
      cmd      = '0;
      cmd.lvl  = lvl_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_is_write) begin
                  cmd.wr_en = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_CAM_CMP;
               end
            end
         end
         ST_CAM_CMP: begin
            cmd.cam_cmp = 1'b1;
            state_in    = ST_CAM_SEL;
         end
         ST_CAM_SEL: begin
            if (sts.cam_hit) begin
               cmd.cam_sel = 1'b1;
               state_in    = ST_ROOT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_ROOT: begin
            cmd.root_load = 1'b1;
            lvl_in        = '0;
            wcnt_in       = '0;
            state_in      = ST_READ;
         end
         ST_READ: begin
            // Words are issued on counts 0..3 and captured on the count after each issue.
            cmd.rd_issue = (wcnt_ff != 3'd4);
            cmd.rd_word  = wcnt_ff[1:0];
            cmd.cap_en   = (wcnt_ff != 3'd0);
            cmd.cap_word = 2'(wcnt_ff - 3'd1);
            if (wcnt_ff == 3'd4) begin
               wcnt_in  = '0;
               state_in = ST_DECIDE;
            end else begin
               wcnt_in = wcnt_ff + 3'd1;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.cnt_en   = 1'b1;
            cmd.cnt_word = wcnt_ff[1:0];
            if (wcnt_ff == 3'd3) begin
               wcnt_in  = '0;
               state_in = ST_NEXT;
            end else begin
               wcnt_in = wcnt_ff + 3'd1;
            end
         end
         ST_NEXT: begin
            cmd.next_lvl = 1'b1;
            state_in     = sts.walk_end ? ST_FINISH : ST_SUB;
         end
         ST_SUB: begin
            cmd.sub_load = 1'b1;
            lvl_in       = lvl_ff + LVL_W'(1);
            state_in     = ST_READ;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output word valid: set on load, cleared when taken.
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wcnt_ff      <= '0;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wcnt_ff      <= wcnt_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A waiting word is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten before it was taken");

   // The walk never goes past the last trie level.
   a_lvl_bound: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LVL_W'(TRIE_KEY_BYTES))
      else $error("trie level out of range");

   // An accepted word makes the input side busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted twice in a row");

   // The word counter stays within the four bitmap words plus the capture slot.
   a_wcnt_bound: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= 3'd4)
      else $error("word counter out of range");

endmodule

`default_nettype wire

>>> hw/rtl/tblpm_dp.sv
// Datapath of the tree-bitmap LPM lookup unit: CAM, table memories, walk and popcounts.
// Depends on tblpm_pkg; sequenced by tblpm_ctrl through cmd_type.
`default_nettype none

module tblpm_dp
   import tblpm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_word_type req_word,
   input  wire cmd_type      cmd,
   output sts_type           sts,
   output rsp_word_type      rsp_word
);

   // CAM entries live in flip-flops so that reset can mark them invalid.
   logic [31:0] cam_keys_ff    [CAM_ENTRIES];
   logic [31:0] cam_inverts_ff [CAM_ENTRIES];

   // Table memories with registered reads.
   logic [REC_W-1:0] root_mem   [CAM_ENTRIES];
   logic [REC_W-1:0] sub_mem    [SUBTRIE_DEPTH];
   logic [63:0]      prefix_mem [4*NODE_STORE_DEPTH];
   logic [63:0]      child_mem  [4*NODE_STORE_DEPTH];
   logic [ACT_W-1:0] action_mem [NODE_STORE_DEPTH];

   logic [REC_W-1:0] root_rd_ff, sub_rd_ff;
   logic [63:0]      prefix_rd_ff, child_rd_ff;
   logic [ACT_W-1:0] action_rd_ff;

   // Lookup working registers.
   logic [31:0]          cam_key_ff;
   logic [63:0]          key_hi_ff, key_lo_ff;
   logic [7:0]           rem_ff;
   logic [CAM_ENTRIES-1:0] match_ff;
   logic [PTR_W-1:0]     node_ff, cbase_ff;
   logic [63:0]          pm_ff [4];
   logic [63:0]          cm_ff [4];
   logic [ACT_W-1:0]     ab_ff;
   logic [7:0]           pos_ff;
   logic                 lvl_hit_ff, walk_end_ff;
   logic [CNT_W-1:0]     pcnt_ff, ccnt_ff;
   logic                 hit_ff;
   logic [APTR_W-1:0]    ptr_ff;
   rsp_word_type         rsp_ff;

   logic [CAM_ENTRIES-1:0] match_in;
   logic [CAM_AW-1:0]      cam_idx;
   logic [7:0]             rem_in;
   logic [63:0]            byte_src;
   logic [7:0]             kb;
   logic [7:0]             pos_in;
   logic                   lvl_hit_in, walk_end_in;
   logic [WORD_AW-1:0]     wr_addr, rd_addr;
   logic [SUB_AW-1:0]      sub_addr;
   logic                   cam_idx_ok;

   // Remaining trie bits, clamped to the trie key size.
   always_comb begin
      if (req_word.key_length < 8'd32) begin
         rem_in = '0;
      end else if ((req_word.key_length - 8'd32) > 8'(MAX_TRIE)) begin
         rem_in = 8'(MAX_TRIE);
      end else begin
         rem_in = req_word.key_length - 8'd32;
      end
   end

   // Parallel CAM compare of all entries.
   always_comb begin
      for (int i = 0; i < CAM_ENTRIES; i++) begin
         match_in[i] = ((cam_keys_ff[i] & cam_inverts_ff[i]) == 32'd0) &&
            ((cam_key_ff & (cam_keys_ff[i] ^ cam_inverts_ff[i])) ==
             (cam_keys_ff[i] & (cam_keys_ff[i] ^ cam_inverts_ff[i])));
      end
   end

   // Highest matching index wins.
   always_comb begin
      cam_idx = '0;
      for (int i = 0; i < CAM_ENTRIES; i++) begin
         if (match_ff[i]) begin
            cam_idx = CAM_AW'(i);
         end
      end
   end

   // Key byte of the current level.
   always_comb begin
      byte_src = cmd.lvl[3] ? key_lo_ff : key_hi_ff;
      kb       = byte_src[{~cmd.lvl[2:0], 3'b000} +: 8];
      if (cmd.lvl >= LVL_W'(TRIE_KEY_BYTES)) begin
         kb = '0;
      end
   end

   // Deepest prefix hit inside the subtrie and the child decision.
   always_comb begin
      logic [7:0] idx;
      pos_in     = '0;
      lvl_hit_in = 1'b0;
      for (int s = 0; s < 8; s++) begin
         idx = 8'((1 << s) - 1) + 8'(kb >> (8 - s));
         if ((rem_ff >= 8'(s)) && pm_ff[idx[7:6]][6'd63 - idx[5:0]]) begin
            pos_in     = idx;
            lvl_hit_in = 1'b1;
         end
      end
      walk_end_in = (rem_ff < 8'd8) || !cm_ff[kb[7:6]][6'd63 - kb[5:0]];
   end

   assign cam_idx_ok = (req_word.write_index < 10'(CAM_ENTRIES));
   assign wr_addr    = {NODE_AW'(req_word.write_index), req_word.write_word};
   assign rd_addr    = {NODE_AW'(node_ff), cmd.rd_word};
   assign sub_addr   = SUB_AW'(cbase_ff + PTR_W'(ccnt_ff));

   // CAM key and invert storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAM_ENTRIES; i++) begin
            cam_keys_ff[i]    <= '1;
            cam_inverts_ff[i] <= '1;
         end
      end else if (cmd.wr_en && cam_idx_ok) begin
         if (req_word.write_target == TGT_CAM_KEY) begin
            cam_keys_ff[CAM_AW'(req_word.write_index)] <= req_word.write_data[31:0];
         end
         if (req_word.write_target == TGT_CAM_INVERT) begin
            cam_inverts_ff[CAM_AW'(req_word.write_index)] <= req_word.write_data[31:0];
         end
      end
   end

   // Table memory writes and registered reads.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         if (req_word.write_target == TGT_CAM_ROOT && cam_idx_ok) begin
            root_mem[CAM_AW'(req_word.write_index)] <= req_word.write_data[REC_W-1:0];
         end
         if (req_word.write_target == TGT_SUB_REC) begin
            sub_mem[SUB_AW'(req_word.write_index)] <= req_word.write_data[REC_W-1:0];
         end
         if (req_word.write_target == TGT_PREFIX) begin
            prefix_mem[wr_addr] <= req_word.write_data;
         end
         if (req_word.write_target == TGT_CHILD) begin
            child_mem[wr_addr] <= req_word.write_data;
         end
         if (req_word.write_target == TGT_ACTION) begin
            action_mem[NODE_AW'(req_word.write_index)] <= req_word.write_data[ACT_W-1:0];
         end
      end
      if (cmd.cam_sel) begin
         root_rd_ff <= root_mem[cam_idx];
      end
      if (cmd.rd_issue) begin
         prefix_rd_ff <= prefix_mem[rd_addr];
         child_rd_ff  <= child_mem[rd_addr];
         action_rd_ff <= action_mem[NODE_AW'(node_ff)];
      end
      if (cmd.next_lvl) begin
         sub_rd_ff <= sub_mem[sub_addr];
      end
   end

   // Walk registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cam_key_ff <= req_word.cam_key;
         key_hi_ff  <= req_word.trie_key_high;
         key_lo_ff  <= req_word.trie_key_low;
         rem_ff     <= rem_in;
      end
      if (cmd.cam_cmp) begin
         match_ff <= match_in;
      end
      if (cmd.root_load) begin
         node_ff  <= root_rd_ff[PTR_W-1:0];
         cbase_ff <= root_rd_ff[REC_W-1:PTR_W];
      end
      if (cmd.cap_en) begin
         pm_ff[cmd.cap_word] <= prefix_rd_ff;
         cm_ff[cmd.cap_word] <= child_rd_ff;
         if (cmd.cap_word == 2'd0) begin
            ab_ff <= action_rd_ff;
         end
      end
      if (cmd.decide) begin
         pos_ff      <= pos_in;
         lvl_hit_ff  <= lvl_hit_in;
         walk_end_ff <= walk_end_in;
      end
      if (cmd.sub_load) begin
         node_ff  <= sub_rd_ff[PTR_W-1:0];
         cbase_ff <= sub_rd_ff[REC_W-1:PTR_W];
         rem_ff   <= rem_ff - 8'd8;
      end
   end

   // One bitmap word of popcount per cycle for the action and child offsets.
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         pcnt_ff <= '0;
         ccnt_ff <= '0;
      end else if (cmd.cnt_en) begin
         pcnt_ff <= pcnt_ff + CNT_W'(popcount64(pm_ff[cmd.cnt_word] &
                                                before_mask(cmd.cnt_word, pos_ff)));
         ccnt_ff <= ccnt_ff + CNT_W'(popcount64(cm_ff[cmd.cnt_word] &
                                                before_mask(cmd.cnt_word, kb)));
      end
   end

   // Deepest hit so far.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.load_req) begin
         hit_ff <= 1'b0;
      end else if (cmd.next_lvl && lvl_hit_ff) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         ptr_ff <= '0;
      end else if (cmd.next_lvl && lvl_hit_ff) begin
         ptr_ff <= APTR_W'(ab_ff) + APTR_W'(pcnt_ff);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.hit           <= hit_ff;
         rsp_ff.forward_index <= hit_ff ? {ptr_ff, 4'b0000} : 21'd0;
      end
   end

   assign sts.cam_hit  = (match_ff != '0);
   assign sts.walk_end = walk_end_ff;
   assign rsp_word     = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/tcam_tree_bitmap_lpm_lookup_unit.sv
// Top level of the TCAM plus tree-bitmap longest prefix match lookup unit.
// Depends on tblpm_pkg, tblpm_ctrl and tblpm_dp.
//
//   Channel   Direction  Handshake              Word
//   req_      in         req_valid / req_ready  req_word_type
//   rsp_      out        rsp_valid / rsp_ready  rsp_word_type
//
// A table write goes from acceptance straight to its result word; a CAM miss skips the walk.
// A lookup walks one trie level after another (up to 17 levels): each level reads four
// 64-bit bitmap words from the single read port and counts one word a cycle.
// Reset marks all CAM entries invalid; the other tables hold nothing until written.
// One word is in work at a time; a finished result waits in the output register while the
// next word is accepted, and a stalled output only holds the next finished result.
`default_nettype none

module tcam_tree_bitmap_lpm_lookup_unit
   import tblpm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   cmd_type cmd;
   sts_type sts;

   tblpm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_is_write (req_word.req_type == REQ_WRITE),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .sts          (sts),
      .cmd          (cmd)
   );

   tblpm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire
